@@ rtl/core/amhi_pkg.sv @@
// ----------------------------------------------------------------------------
// amhi_pkg: shared types and constants of the axis motion homing integrator
// Register indexes, reset values, lane command and lane configuration bundles.
// ----------------------------------------------------------------------------
package amhi_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int NUM_AXES       = 3;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam int PARAM_BITS     = 31;
  localparam int STEP17_BITS    = 36;
  localparam int DIGIT_BITS     = 12;

  localparam logic [PARAM_BITS-1:0]           RST_MAX_SPEED  = 31'd1000;
  localparam logic [PARAM_BITS-1:0]           RST_STEP       = 31'd1000;
  localparam logic [PARAM_BITS-1:0]           RST_SLOW_RANGE = 31'd1000;
  localparam logic signed [CFG_DATA_BITS-1:0] RST_VEL_FLOOR  = 32'sh8000_0000;
  localparam logic signed [CFG_DATA_BITS-1:0] RST_VEL_CEIL   = 32'sh7fff_ffff;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_HOMING_ENABLE = 3'd0,
    REG_MAX_SPEED     = 3'd1,
    REG_STEP          = 3'd2,
    REG_SLOW_RANGE    = 3'd3,
    REG_VEL_FLOOR     = 3'd4,
    REG_VEL_CEILING   = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    K_LOAD,
    K_TICK,
    K_HOME,
    K_CLAMP
  } lane_kind_t;

  typedef struct packed {
    logic       start;
    logic       go;
    lane_kind_t kind;
  } lane_cmd_t;

  typedef struct packed {
    logic [PARAM_BITS-1:0]           max_speed;
    logic [PARAM_BITS-1:0]           step;
    logic [PARAM_BITS-1:0]           slow_range;
    logic [STEP17_BITS-1:0]          step17;
    logic signed [CFG_DATA_BITS-1:0] lo;
    logic signed [CFG_DATA_BITS-1:0] hi;
  } lane_cfg_t;

endpackage

@@ rtl/core/amhi_if.sv @@
// ----------------------------------------------------------------------------
// amhi_if: item and result channels of the axis motion homing integrator
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface amhi_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic signed [31:0] vector_x;
  logic signed [31:0] vector_y;
  logic signed [31:0] vector_z;

  modport source (output valid, opcode, point_x, point_y, point_z,
                  vector_x, vector_y, vector_z, input ready);
  modport sink (input valid, opcode, point_x, point_y, point_z,
                vector_x, vector_y, vector_z, output ready);
endinterface

interface amhi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;

  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                output ready);
endinterface

@@ rtl/core/axis_motion_homing_integrator_top.sv @@
// ----------------------------------------------------------------------------
// axis_motion_homing_integrator_top: three-axis motion integrator with homing
// Load items and plain ticks need no multiply-divide pass; a homing tick runs up
// to three back-to-back multiply-divide passes in each axis lane.
// One item is in flight at a time; a waiting result does not block taking the
// next item, but the next result is held back until the waiting one is taken.
// Synchronous reset restores register defaults and zeroes all axes at once.
module axis_motion_homing_integrator_top #(
  parameter int COORD_BITS = amhi_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  amhi_in_if.sink                              item,
  amhi_out_if.source                           result,
  input  logic                                 cfg_we,
  input  logic [amhi_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [amhi_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int NA = amhi_pkg::NUM_AXES;
  localparam int PB = amhi_pkg::PARAM_BITS;
  localparam int MW = (COORD_BITS > 32) ? COORD_BITS : 32;
  localparam int OW = MW + 1;
  localparam int DW = OW + 4;

  typedef enum logic [2:0] {T_IDLE, T_OFFS, T_MERGE, T_RUN, T_CLAMP} top_state_t;

  top_state_t          state;
  logic                clamp_pend;
  logic [NA-1:0]       done_seen;
  amhi_pkg::lane_cmd_t cmd;
  logic                capture;

  logic                homing_enable;
  logic [PB-1:0]       max_speed;
  logic [PB-1:0]       step;
  logic [PB-1:0]       slow_range;
  logic signed [31:0]  vel_floor;
  logic signed [31:0]  vel_ceil;

  logic signed [31:0]  pt  [NA];
  logic signed [31:0]  vec [NA];

  logic                rv;
  logic signed [31:0]  rpos [NA];
  logic signed [31:0]  rvel [NA];

  amhi_pkg::lane_cfg_t           cfg;
  logic [NA-1:0][OW-1:0]         ab;
  logic [OW-1:0]                 dmax;
  logic [DW-1:0]                 dmax10;
  logic [NA-1:0]                 lane_done;
  logic signed [COORD_BITS-1:0]  pos [NA];
  logic signed [COORD_BITS-1:0]  vel [NA];
  logic                          all_done;
  logic                          in_ready;

  assign cfg.max_speed  = max_speed;
  assign cfg.step       = step;
  assign cfg.slow_range = slow_range;
  assign cfg.step17     = (amhi_pkg::STEP17_BITS'(step) << 4) + amhi_pkg::STEP17_BITS'(step);
  assign cfg.lo         = (vel_floor < vel_ceil) ? vel_floor : vel_ceil;
  assign cfg.hi         = (vel_floor < vel_ceil) ? vel_ceil : vel_floor;

  assign all_done = &(done_seen | lane_done);
  assign in_ready = (state == T_IDLE) && !clamp_pend;

  assign item.ready   = in_ready;
  assign result.valid = rv;
  assign result.pos_x = rpos[0];
  assign result.pos_y = rpos[1];
  assign result.pos_z = rpos[2];
  assign result.vel_x = rvel[0];
  assign result.vel_y = rvel[1];
  assign result.vel_z = rvel[2];

  for (genvar g = 0; g < NA; g++) begin : g_lane
    amhi_lane #(.CB(COORD_BITS)) u_lane (
      .clk    (clk),
      .rst    (rst),
      .cmd    (cmd),
      .cfg    (cfg),
      .point  (pt[g]),
      .vector (vec[g]),
      .dmax   (dmax),
      .dmax10 (dmax10),
      .ab     (ab[g]),
      .done   (lane_done[g]),
      .pos    (pos[g]),
      .vel    (vel[g])
    );
  end

  amhi_merge #(.OW(OW), .DW(DW)) u_merge (
    .clk     (clk),
    .capture (capture),
    .ab      (ab),
    .dmax    (dmax),
    .dmax10  (dmax10)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_IDLE;
      clamp_pend    <= 1'b0;
      done_seen     <= '0;
      cmd           <= '{start: 1'b0, go: 1'b0, kind: amhi_pkg::K_TICK};
      capture       <= 1'b0;
      rv            <= 1'b0;
      homing_enable <= 1'b0;
      max_speed     <= amhi_pkg::RST_MAX_SPEED;
      step          <= amhi_pkg::RST_STEP;
      slow_range    <= amhi_pkg::RST_SLOW_RANGE;
      vel_floor     <= amhi_pkg::RST_VEL_FLOOR;
      vel_ceil      <= amhi_pkg::RST_VEL_CEIL;
    end else begin
      cmd.start <= 1'b0;
      cmd.go    <= 1'b0;
      capture   <= 1'b0;
      done_seen <= done_seen | lane_done;
      if (result.valid && result.ready) begin
        rv <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (clamp_pend) begin
            clamp_pend <= 1'b0;
            cmd.start  <= 1'b1;
            cmd.kind   <= amhi_pkg::K_CLAMP;
            done_seen  <= '0;
            state      <= T_CLAMP;
          end else if (item.valid) begin
            pt[0]     <= item.point_x;
            pt[1]     <= item.point_y;
            pt[2]     <= item.point_z;
            vec[0]    <= item.vector_x;
            vec[1]    <= item.vector_y;
            vec[2]    <= item.vector_z;
            cmd.start <= 1'b1;
            done_seen <= '0;
            if (item.opcode) begin
              cmd.kind <= amhi_pkg::K_LOAD;
              state    <= T_RUN;
            end else if (homing_enable) begin
              cmd.kind <= amhi_pkg::K_HOME;
              state    <= T_OFFS;
            end else begin
              cmd.kind <= amhi_pkg::K_TICK;
              state    <= T_RUN;
            end
          end
        end
        T_OFFS: begin
          capture <= 1'b1;
          state   <= T_MERGE;
        end
        T_MERGE: begin
          cmd.go <= 1'b1;
          state  <= T_RUN;
        end
        T_RUN: begin
          if (all_done && (!rv || result.ready)) begin
            for (int k = 0; k < NA; k++) begin
              rpos[k] <= 32'(pos[k]);
              rvel[k] <= 32'(vel[k]);
            end
            rv    <= 1'b1;
            state <= T_IDLE;
          end
        end
        T_CLAMP: begin
          if (all_done) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
      // A bound write re-clamps the stored velocities; a new write re-arms it.
      if (cfg_we) begin
        unique case (amhi_pkg::reg_index_t'(cfg_index))
          amhi_pkg::REG_HOMING_ENABLE: homing_enable <= cfg_data[0];
          amhi_pkg::REG_MAX_SPEED:     max_speed     <= cfg_data[PB-1:0];
          amhi_pkg::REG_STEP:          step          <= cfg_data[PB-1:0];
          amhi_pkg::REG_SLOW_RANGE:    slow_range    <= cfg_data[PB-1:0];
          amhi_pkg::REG_VEL_FLOOR: begin
            vel_floor  <= signed'(cfg_data);
            clamp_pend <= 1'b1;
          end
          amhi_pkg::REG_VEL_CEILING: begin
            vel_ceil   <= signed'(cfg_data);
            clamp_pend <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  a_result_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == T_RUN))
    else $error("result beat raised outside the run state");

  a_result_follows_done: assert property (@(posedge clk) disable iff (rst)
    (state == T_RUN && all_done && !result.valid) |=> result.valid)
    else $error("finished lanes did not produce a result beat");

  a_no_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    (state == T_IDLE) |-> (lane_done == '0))
    else $error("lane reported done while no item was in flight");

endmodule

@@ rtl/core/amhi_muldiv.sv @@
// ----------------------------------------------------------------------------
// amhi_muldiv: sequential trunc(a * b / c) unit
// Digit-serial multiply, then one restoring quotient bit per cycle. The
// quotient saturates to all ones when it does not fit in QW bits.
// ----------------------------------------------------------------------------
module amhi_muldiv #(
  parameter int AW = 33,
  parameter int BW = 36,
  parameter int CW = 37,
  parameter int QW = 34
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  input  logic [CW-1:0] c,
  output logic          done,
  output logic [QW-1:0] q
);

  localparam int PW = AW + BW;
  localparam int DG = amhi_pkg::DIGIT_BITS;
  localparam int ND = (BW + DG - 1) / DG;
  localparam int KW = (ND > 1) ? $clog2(ND) : 1;
  localparam int NW = (QW > 1) ? $clog2(QW) : 1;

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_LOAD, M_DIV} md_state_t;

  md_state_t       state;
  logic [KW-1:0]   k;
  logic [NW-1:0]   cnt;
  logic [AW-1:0]   a_r;
  logic [BW-1:0]   b_r;
  logic [CW-1:0]   c_r;
  logic [PW-1:0]   acc;
  logic [CW-1:0]   rem;
  logic [QW-1:0]   lowq;

  logic [AW+DG-1:0] pp;
  logic [CW:0]      sh;
  logic             ge;

  assign pp = a_r * b_r[DG-1:0];
  assign sh = {rem, lowq[QW-1]};
  assign ge = sh >= {1'b0, c_r};
  assign q  = lowq;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
      k     <= '0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (start) begin
            a_r   <= a;
            b_r   <= b;
            c_r   <= c;
            acc   <= '0;
            k     <= '0;
            state <= M_MUL;
          end
        end
        M_MUL: begin
          acc <= acc + (PW'(pp) << (DG * k));
          b_r <= b_r >> DG;
          if (k == KW'(ND - 1)) begin
            state <= M_LOAD;
          end else begin
            k <= k + 1'b1;
          end
        end
        M_LOAD: begin
          if ((acc >> QW) >= PW'(c_r)) begin
            lowq  <= '1;
            done  <= 1'b1;
            state <= M_IDLE;
          end else begin
            rem   <= CW'(acc >> QW);
            lowq  <= acc[QW-1:0];
            cnt   <= '0;
            state <= M_DIV;
          end
        end
        M_DIV: begin
          rem  <= ge ? CW'(sh - {1'b0, c_r}) : sh[CW-1:0];
          lowq <= {lowq[QW-2:0], ge};
          if (cnt == NW'(QW - 1)) begin
            done  <= 1'b1;
            state <= M_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/amhi_lane.sv @@
// ----------------------------------------------------------------------------
// amhi_lane: one axis of the motion integrator
// Holds position and velocity of its axis, computes the homing velocity with
// its own multiply-divide unit, then clamps the velocity and integrates it.
// ----------------------------------------------------------------------------
module amhi_lane #(
  parameter int CB = amhi_pkg::COORD_BITS_DEF,
  localparam int MW = (CB > 32) ? CB : 32,
  localparam int OW = MW + 1,
  localparam int DW = OW + 4
) (
  input  logic                clk,
  input  logic                rst,
  input  amhi_pkg::lane_cmd_t cmd,
  input  amhi_pkg::lane_cfg_t cfg,
  input  logic signed [31:0]  point,
  input  logic signed [31:0]  vector,
  input  logic [OW-1:0]       dmax,
  input  logic [DW-1:0]       dmax10,
  output logic [OW-1:0]       ab,
  output logic                done,
  output logic signed [CB-1:0] pos,
  output logic signed [CB-1:0] vel
);

  localparam int QB = OW + 1;
  localparam int VW = QB + 1;
  localparam int XW = VW + 1;
  localparam int BW = amhi_pkg::STEP17_BITS;
  localparam int PB = amhi_pkg::PARAM_BITS;

  typedef enum logic [3:0] {
    L_IDLE, L_WAIT, L_SOI, L_SOW, L_STI, L_STW, L_DMI, L_DMW, L_FIN
  } lane_state_t;

  lane_state_t          state;
  logic                 neg;
  logic [PB-1:0]        so;
  logic [PB-1:0]        stp;
  logic signed [VW-1:0] vh;

  logic                 md_start;
  logic                 md_done;
  logic [OW-1:0]        md_a;
  logic [BW-1:0]        md_b;
  logic [DW-1:0]        md_c;
  logic [QB-1:0]        md_q;

  logic signed [OW-1:0] off;
  logic signed [VW-1:0] dmv, want, last, stp_s, lo_l, hi_l, want_c;
  logic signed [XW-1:0] vsum;
  logic signed [CB-1:0] vfin;

  function automatic logic signed [CB-1:0] clampv(input logic signed [XW-1:0] x,
                                                  input logic signed [31:0] lo,
                                                  input logic signed [31:0] hi);
    logic signed [XW-1:0] cmax, cmin, v, l, h;
    cmax = XW'({1'b0, {(CB-1){1'b1}}});
    cmin = ~cmax;
    l    = XW'(lo);
    h    = XW'(hi);
    v    = (x > cmax) ? cmax : ((x < cmin) ? cmin : x);
    if (v > h) begin
      v = h;
    end else if (v < l) begin
      v = l;
    end
    v = (v > cmax) ? cmax : ((v < cmin) ? cmin : v);
    return v[CB-1:0];
  endfunction

  amhi_muldiv #(.AW(OW), .BW(BW), .CW(DW), .QW(QB)) u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .a     (md_a),
    .b     (md_b),
    .c     (md_c),
    .done  (md_done),
    .q     (md_q)
  );

  // Operands are chosen by the issue state; the unit latches them on start.
  always_comb begin
    md_start = 1'b0;
    md_a     = ab;
    md_b     = BW'(cfg.max_speed);
    md_c     = DW'(dmax);
    unique case (state)
      L_SOI: md_start = 1'b1;
      L_STI: begin
        md_start = (dmax != '0);
        md_b     = cfg.step17;
        md_c     = dmax10;
      end
      L_DMI: begin
        md_start = 1'b1;
        md_a     = OW'(so);
        md_c     = (cfg.slow_range == '0) ? DW'(1) : DW'(cfg.slow_range);
      end
      default: ;
    endcase
  end

  assign off    = OW'(point) - OW'(pos);
  assign dmv    = signed'({1'b0, md_q});
  assign want   = neg ? -dmv : dmv;
  assign last   = VW'(vel);
  assign stp_s  = signed'(VW'(stp));
  assign lo_l   = last - stp_s;
  assign hi_l   = last + stp_s;
  assign want_c = (want < lo_l) ? lo_l : ((want > hi_l) ? hi_l : want);
  assign vsum   = XW'(vh) + XW'(vector);
  assign vfin   = clampv(vsum, cfg.lo, cfg.hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
      pos   <= '0;
      vel   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (cmd.start) begin
            unique case (cmd.kind)
              amhi_pkg::K_LOAD: begin
                pos  <= CB'(point);
                vel  <= clampv(XW'(vector), cfg.lo, cfg.hi);
                done <= 1'b1;
              end
              amhi_pkg::K_CLAMP: begin
                vel  <= clampv(XW'(vel), cfg.lo, cfg.hi);
                done <= 1'b1;
              end
              amhi_pkg::K_TICK: begin
                vh    <= VW'(vel);
                state <= L_FIN;
              end
              amhi_pkg::K_HOME: begin
                ab    <= off[OW-1] ? OW'(-off) : OW'(off);
                neg   <= off[OW-1];
                state <= L_WAIT;
              end
              default: ;
            endcase
          end
        end
        L_WAIT: begin
          if (cmd.go) begin
            if (dmax > OW'(cfg.max_speed)) begin
              state <= L_SOI;
            end else begin
              // The offset is already within the speed limit, so it is used as is.
              so    <= ab[PB-1:0];
              state <= L_STI;
            end
          end
        end
        L_SOI: state <= L_SOW;
        L_SOW: begin
          if (md_done) begin
            so    <= md_q[PB-1:0];
            state <= L_STI;
          end
        end
        L_STI: begin
          if (dmax == '0) begin
            stp   <= cfg.step;
            state <= L_DMI;
          end else begin
            state <= L_STW;
          end
        end
        L_STW: begin
          if (md_done) begin
            stp   <= (md_q < QB'(cfg.step)) ? md_q[PB-1:0] : cfg.step;
            state <= L_DMI;
          end
        end
        L_DMI: state <= L_DMW;
        L_DMW: begin
          if (md_done) begin
            vh    <= want_c;
            state <= L_FIN;
          end
        end
        L_FIN: begin
          vel   <= vfin;
          pos   <= pos + vfin;
          done  <= 1'b1;
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/amhi_merge.sv @@
// ----------------------------------------------------------------------------
// amhi_merge: combines the per-axis offset magnitudes
// Registers the largest magnitude over the axes and ten times that value.
// ----------------------------------------------------------------------------
module amhi_merge #(
  parameter int OW = 33,
  parameter int DW = 37
) (
  input  logic                                  clk,
  input  logic                                  capture,
  input  logic [amhi_pkg::NUM_AXES-1:0][OW-1:0] ab,
  output logic [OW-1:0]                         dmax,
  output logic [DW-1:0]                         dmax10
);

  logic [OW-1:0] m01, m;

  assign m01 = (ab[0] > ab[1]) ? ab[0] : ab[1];
  assign m   = (ab[2] > m01) ? ab[2] : m01;

  always_ff @(posedge clk) begin
    if (capture) begin
      dmax   <= m;
      dmax10 <= (DW'(m) << 3) + (DW'(m) << 1);
    end
  end

endmodule
